FILE: src/assert_macros.svh
// Assertion macros for the RTL file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds when the consequent is true in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Holds when the consequent is true in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/y2r_pkg.sv
// Package with request and response types and chroma tables for the YUV to RGB565 block.
`default_nettype none

package y2r_pkg;

    localparam int DenMilli = 1000;
    localparam int DenMicro = 100000;
    localparam int CoefUb   = 1772;
    localparam int CoefUg   = 34414;
    localparam int CoefVg   = 71414;
    localparam int CoefVr   = 1402;
    localparam int RomDepth = 256;

    typedef logic signed [8:0]  t_term;
    typedef logic signed [10:0] t_sum;
    typedef t_term t_rom [RomDepth];

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_req;

    typedef struct packed {
        logic [31:0] top_pixel_pair;
        logic [31:0] bottom_pixel_pair;
    } t_rsp;

    function automatic t_rom f_rom_milli(input int num);
        t_rom rom;
        int   d;
        for (int i = 0; i < RomDepth; i++) begin
            d      = i - 128;
            rom[i] = t_term'((num * d) / DenMilli);
        end
        return rom;
    endfunction

    function automatic t_rom f_rom_micro(input int num);
        t_rom rom;
        int   d;
        for (int i = 0; i < RomDepth; i++) begin
            d      = i - 128;
            rom[i] = t_term'((num * d) / DenMicro);
        end
        return rom;
    endfunction

    localparam t_rom UB_ROM = f_rom_milli(CoefUb);
    localparam t_rom UG_ROM = f_rom_micro(CoefUg);
    localparam t_rom VG_ROM = f_rom_micro(CoefVg);
    localparam t_rom VR_ROM = f_rom_milli(CoefVr);

    function automatic logic [7:0] f_clamp(input t_sum x);
        logic [7:0] c;
        if (x < 0) begin
            c = 8'd0;
        end else if (x > 11'sd255) begin
            c = 8'hFF;
        end else begin
            c = x[7:0];
        end
        return c;
    endfunction

    function automatic logic [15:0] f_pixel(input logic [7:0] y, input t_term ub,
                                            input t_term ug, input t_term vg,
                                            input t_term vr);
        t_sum       ys;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        ys = $signed({3'b000, y});
        b  = f_clamp(ys + t_sum'(ub));
        g  = f_clamp(ys - t_sum'(ug) - t_sum'(vg));
        r  = f_clamp(ys + t_sum'(vr));
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

FILE: src/yuv420_block_to_rgb565.sv
// Top level: converts 2x2 YUV 4:2:0 blocks into two packed RGB565 pixel pairs each.
//
//   Channel   Valid     Stall     Payload
//   request   i_valid   o_stall   i_req  (y2r_pkg::t_req)
//   response  o_valid   i_stall   o_rsp  (y2r_pkg::t_rsp)
//
// A request is registered on acceptance, converted by table look-ups, adds and clamps,
// and its response is then registered in the output register. One request can be
// accepted every cycle while i_stall is low; the rate is set by the two register stages.
// A stalled response holds the output register; the input register then holds its
// request and o_stall rises only when both stages are full.
// Synchronous active-low reset clears both valid flags.
`default_nettype none

`include "assert_macros.svh"

module yuv420_block_to_rgb565 (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire y2r_pkg::t_req   i_req,
    output logic                 o_valid,
    input  wire                  i_stall,
    output y2r_pkg::t_rsp        o_rsp
);

    logic           r_in_valid;
    y2r_pkg::t_req  r_in;
    logic           r_out_valid;
    y2r_pkg::t_rsp  r_out;
    y2r_pkg::t_rsp  n_out;
    logic           s_adv;
    logic           s_take;
    y2r_pkg::t_term s_ub;
    y2r_pkg::t_term s_ug;
    y2r_pkg::t_term s_vg;
    y2r_pkg::t_term s_vr;

    assign s_adv   = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !s_adv;
    assign s_take  = i_valid && !o_stall;

    always_comb begin
        s_ub = y2r_pkg::UB_ROM[r_in.chroma_blue];
        s_ug = y2r_pkg::UG_ROM[r_in.chroma_blue];
        s_vg = y2r_pkg::VG_ROM[r_in.chroma_red];
        s_vr = y2r_pkg::VR_ROM[r_in.chroma_red];
        n_out.top_pixel_pair = {
            y2r_pkg::f_pixel(r_in.luma_top_right, s_ub, s_ug, s_vg, s_vr),
            y2r_pkg::f_pixel(r_in.luma_top_left, s_ub, s_ug, s_vg, s_vr)};
        n_out.bottom_pixel_pair = {
            y2r_pkg::f_pixel(r_in.luma_bottom_right, s_ub, s_ug, s_vg, s_vr),
            y2r_pkg::f_pixel(r_in.luma_bottom_left, s_ub, s_ug, s_vg, s_vr)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (s_adv || !r_in_valid) begin
                r_in_valid  <= s_take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in <= i_req;
        end
        if (s_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    `ASSERT_NEXT(a_take_fills_input, i_clk, i_rst_n, s_take, r_in_valid,
        "Accepted request did not reach the input register.")
    `ASSERT_NEXT(a_input_moves_on, i_clk, i_rst_n, r_in_valid && s_adv, r_out_valid,
        "Input register advanced without producing a response.")
    `ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, o_stall,
        r_in_valid && r_out_valid,
        "Request stalled while a stage was free.")
    `ASSERT_NEXT(a_held_request_stable, i_clk, i_rst_n,
        r_in_valid && r_out_valid && i_stall, $stable(r_in),
        "Held request changed while the response was stalled.")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the 2x2 YUV 4:2:0 block to RGB565 pixel-pair converter.
`timescale 1ns / 100ps

module tb;

    localparam int IdleLimit  = 1000;
    localparam int LongHold   = 80;
    localparam int PhaseSize  = 100;
    localparam int PhaseCount = 5;

    class pair_tracker;
        y2r_pkg::t_rsp pending_pairs[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function int sat8(int x);
            return (x < 0) ? 0 : ((x > 255) ? 255 : x);
        endfunction

        function logic [15:0] rgb565(logic [7:0] y, int ub, int ug, int vg, int vr);
            int luma;
            int b;
            int g;
            int r;
            luma = int'(y);
            b    = sat8(luma + ub);
            g    = sat8(luma - ug - vg);
            r    = sat8(luma + vr);
            return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | (b >> 3));
        endfunction

        function y2r_pkg::t_rsp convert_block(y2r_pkg::t_req blk);
            int            du;
            int            dv;
            int            ub;
            int            ug;
            int            vg;
            int            vr;
            y2r_pkg::t_rsp pairs;
            du = int'(blk.chroma_blue) - 128;
            dv = int'(blk.chroma_red) - 128;
            ub = (1772 * du) / 1000;
            ug = (34414 * du) / 100000;
            vg = (71414 * dv) / 100000;
            vr = (1402 * dv) / 1000;
            pairs.top_pixel_pair    = {rgb565(blk.luma_top_right, ub, ug, vg, vr),
                                       rgb565(blk.luma_top_left, ub, ug, vg, vr)};
            pairs.bottom_pixel_pair = {rgb565(blk.luma_bottom_right, ub, ug, vg, vr),
                                       rgb565(blk.luma_bottom_left, ub, ug, vg, vr)};
            return pairs;
        endfunction

        function void note_block(y2r_pkg::t_req blk);
            pending_pairs.push_back(convert_block(blk));
        endfunction

        function void check_pairs(y2r_pkg::t_rsp got);
            y2r_pkg::t_rsp want;
            if (pending_pairs.size() == 0) begin
                errors++;
                $display("%0t: response %h arrived with no request outstanding",
                         $time, got);
                return;
            end
            want = pending_pairs.pop_front();
            if (got.top_pixel_pair !== want.top_pixel_pair) begin
                errors++;
                $display("%0t: top_pixel_pair expected %h, got %h",
                         $time, want.top_pixel_pair, got.top_pixel_pair);
            end
            if (got.bottom_pixel_pair !== want.bottom_pixel_pair) begin
                errors++;
                $display("%0t: bottom_pixel_pair expected %h, got %h",
                         $time, want.bottom_pixel_pair, got.bottom_pixel_pair);
            end
        endfunction

        function int outstanding();
            return pending_pairs.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    y2r_pkg::t_req req;
    logic          rsp_valid;
    logic          rsp_stall;
    y2r_pkg::t_rsp rsp;

    pair_tracker board;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          hold_req;
    int          idle_cycles;

    yuv420_block_to_rgb565 uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_req   (req),
        .o_valid (rsp_valid),
        .i_stall (rsp_stall),
        .o_rsp   (rsp)
    );

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        hold_req  = 1'b0;
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                board.note_block(req);
            if (rsp_valid && !rsp_stall)
                board.check_pairs(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always begin
        int hold;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = LongHold;
            end else begin
                hold = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            repeat (hold) begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    task automatic send_block(input y2r_pkg::t_req blk);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= blk;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic send_directed(input logic [7:0] y0, input logic [7:0] y1,
                                 input logic [7:0] y2, input logic [7:0] y3,
                                 input logic [7:0] u, input logic [7:0] v);
        y2r_pkg::t_req blk;
        blk.luma_top_left     = y0;
        blk.luma_top_right    = y1;
        blk.luma_bottom_left  = y2;
        blk.luma_bottom_right = y3;
        blk.chroma_blue       = u;
        blk.chroma_red        = v;
        send_block(blk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'(124 + $urandom_range(0, 8));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drain();
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial begin
        y2r_pkg::t_req blk;
        board       = new();
        idle_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Saturation at both ends, neutral chroma and mixed extremes.
        send_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_directed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_directed(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
        send_directed(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_directed(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_directed(8'd16, 8'd235, 8'd16, 8'd235, 8'h80, 8'h80);
        send_directed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_directed(8'd1, 8'd2, 8'd254, 8'd253, 8'd127, 8'd129);
        send_directed(8'd85, 8'd170, 8'hAA, 8'h55, 8'd1, 8'd254);
        send_directed(8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h80, 8'h7F);
        @(negedge clk);
        req_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < PhaseCount; phase++) begin
            tx_quiet = (phase == 1) || (phase == 2) || (phase == 3);
            rx_quiet = (phase == 1) || (phase == 4);
            // The output side is held off for a long stretch so that the pipeline fills.
            if (phase == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PhaseSize; n++) begin
                blk.luma_top_left     = pick_byte();
                blk.luma_top_right    = pick_byte();
                blk.luma_bottom_left  = pick_byte();
                blk.luma_bottom_right = pick_byte();
                blk.chroma_blue       = pick_byte();
                blk.chroma_red        = pick_byte();
                send_block(blk);
            end
            @(negedge clk);
            req_valid <= 1'b0;
            drain();
        end

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/y2r_pkg.sv
src/yuv420_block_to_rgb565.sv
tb/sv/tb.sv
